@@ sv/imgsig_pkg.sv @@
// ----------------------------------------------------------------------------
// imgsig_pkg
// Signature table and format codes for the image file signature sniffer.
// ----------------------------------------------------------------------------
package imgsig_pkg;

    localparam int unsigned SIG_COUNT  = 12;
    localparam int unsigned SIG_MAXLEN = 12;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned CODE_W     = 4;

    typedef logic [7:0]           byte_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [SIG_COUNT-1:0] flags_t;

    typedef enum logic [CODE_W-1:0] {
        FMT_UNKNOWN = 4'd0,
        FMT_JPEG    = 4'd1,
        FMT_PNG     = 4'd2,
        FMT_TIFF    = 4'd3,
        FMT_DDS     = 4'd4,
        FMT_KTX     = 4'd5,
        FMT_HDR     = 4'd6,
        FMT_TGA     = 4'd7,
        FMT_SGI     = 4'd8
    } format_t;

    // signature bytes, unused tail positions are zero and never compared
    localparam byte_t SIG_BYTES [SIG_COUNT][SIG_MAXLEN] = '{
        '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A,
          8'h1A, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h20, 8'h49, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4D, 8'h00, 8'h2B, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h44, 8'h53, 8'h20, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hAB, 8'h4B, 8'h54, 8'h58, 8'h20, 8'h31,
          8'h31, 8'hBB, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
        '{8'hAB, 8'h4B, 8'h54, 8'h58, 8'h20, 8'h32,
          8'h30, 8'hBB, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
        '{8'h23, 8'h3F, 8'h52, 8'h41, 8'h44, 8'h49,
          8'h41, 8'h4E, 8'h43, 8'h45, 8'h0A, 8'h00},
        '{8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'hDA, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // bytes compared per signature
    localparam pos_t SIG_LEN [SIG_COUNT] = '{
        4'd3, 4'd8, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd12, 4'd12, 4'd11, 4'd3, 4'd2
    };

    // bytes that must have been seen for a full match
    localparam pos_t SIG_NEED [SIG_COUNT] = '{
        4'd3, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd12, 4'd12, 4'd11, 4'd3, 4'd2
    };

    localparam format_t SIG_CODE [SIG_COUNT] = '{
        FMT_JPEG, FMT_PNG, FMT_TIFF, FMT_TIFF, FMT_TIFF, FMT_TIFF,
        FMT_DDS, FMT_KTX, FMT_KTX, FMT_HDR, FMT_TGA, FMT_SGI
    };

endpackage

@@ sv/image_file_signature_sniffer.sv @@
// ----------------------------------------------------------------------------
// image_file_signature_sniffer
// Detects the image format of a file from the magic number at its head.
// ----------------------------------------------------------------------------
// Bytes of a file enter one per transaction from offset zero, last_byte set on
// the final one. Each byte is compared against twelve signatures (jpeg, png,
// four tiff variants, dds, two ktx identifiers, hdr, tga, sgi); a signature
// drops out on its first mismatch. On the final byte one result transaction
// carries format_code, the first signature in table order that matched over
// its whole length with its needed byte count seen (0 when none did); other
// bytes give no result. The block takes one byte per cycle while the output
// is not stalled: an input register feeds one compare stage that updates the
// match state and loads the output register. Files may follow back to back;
// the match state clears itself after the final byte.
module image_file_signature_sniffer #(
    parameter int unsigned HEADER_BYTES = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    // byte stream
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] head_byte,
    input  logic       last_byte,
    // result
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] format_code
);

    localparam imgsig_pkg::pos_t POS_SAT = imgsig_pkg::pos_t'(HEADER_BYTES);

    // input register
    logic              in_valid_reg;
    imgsig_pkg::byte_t byte_reg;
    logic              last_reg;

    // match state
    imgsig_pkg::pos_t   pos_reg,   pos_next;
    imgsig_pkg::flags_t flags_reg, flags_next;

    // output register
    logic                out_valid_reg;
    imgsig_pkg::format_t code_reg, code_next;

    logic advance;
    logic in_accept;

    // the compare stage moves whenever the output register is free or drains
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        imgsig_pkg::pos_t seen;
        flags_next = flags_reg;
        for (int k = 0; k < imgsig_pkg::SIG_COUNT; k++)
        begin
            if (pos_reg < imgsig_pkg::SIG_LEN[k]
                && imgsig_pkg::SIG_BYTES[k][pos_reg] != byte_reg)
            begin
                flags_next[k] = 1'b0;
            end
        end
        // byte count saturates once every signature is past
        seen     = (pos_reg < POS_SAT) ? pos_reg + 4'd1 : pos_reg;
        pos_next = seen;
        // first full match in table order wins, so scan from the back
        code_next = imgsig_pkg::FMT_UNKNOWN;
        for (int k = imgsig_pkg::SIG_COUNT - 1; k >= 0; k--)
        begin
            if (flags_next[k] && seen >= imgsig_pkg::SIG_NEED[k])
            begin
                code_next = imgsig_pkg::SIG_CODE[k];
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance || !in_valid_reg)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= head_byte;
            last_reg <= last_byte;
        end
    end

    // match state, back to the start after the final byte of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            flags_reg <= '1;
        end
        else if (in_valid_reg && advance)
        begin
            if (last_reg)
            begin
                pos_reg   <= '0;
                flags_reg <= '1;
            end
            else
            begin
                pos_reg   <= pos_next;
                flags_reg <= flags_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && last_reg)
        begin
            code_reg <= code_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign format_code = code_reg;

endmodule

@@ sv/imgsig_checker.sv @@
// ----------------------------------------------------------------------------
// imgsig_checker
// Port-level checks for the image file signature sniffer.
// ----------------------------------------------------------------------------
module imgsig_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       last_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] format_code
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(format_code))
        else $error("stalled result changed");

    // input is only held back while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // a fresh result follows a final byte taken into the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && last_byte, 2))
        else $error("result without a final byte");

    // codes stay within the defined formats
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> format_code <= 4'd8)
        else $error("format code out of range");

endmodule

bind image_file_signature_sniffer imgsig_checker u_imgsig_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .format_code (format_code)
);
